>>> rtl/serial_command_frame_receiver_unit_defines.svh
// Assertion macros shared by the checker of the framed command receiver.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef SERIAL_COMMAND_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SCFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfr check failed (same cycle)");

// Next-cycle implication, disabled while in reset.
`define SCFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfr check failed (next cycle)");

`endif

>>> rtl/scfr_pkg.sv
// Shared types, constants and functions of the framed command receiver.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps

package scfr_pkg;

    localparam int SPEED_W = 12;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd1;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET     = 16'd333;
    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hFF;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'hCC;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [SPEED_W-1:0] SPEED_SCALE  = 12'd10;
    localparam logic [SPEED_W-1:0] SPEED_OFFSET = 12'd1000;

    // Frame position, one-hot
    typedef enum logic [6:0] {
        POS_SYNC1  = 7'b0000001,
        POS_SYNC2  = 7'b0000010,
        POS_PAY0   = 7'b0000100,
        POS_PAY1   = 7'b0001000,
        POS_PAY2   = 7'b0010000,
        POS_CRC_HI = 7'b0100000,
        POS_CRC_LO = 7'b1000000
    } pos_t;

    // A tick as handed from the front to the back.
    typedef struct packed {
        logic            fresh;
        logic [2:0][7:0] cmd;
    } tick_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] flipper_speed;
        logic                      fresh_frame;
        logic                      timed_out;
    } result_t;

    // One byte of CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // (b - 100) * 10 in 12-bit two's complement.
    function automatic logic [SPEED_W-1:0] speed_from_byte(input logic [7:0] b);
        logic [SPEED_W-1:0] scaled;
        scaled = SPEED_W'(b) * SPEED_SCALE;
        return scaled - SPEED_OFFSET;
    endfunction

endpackage

>>> rtl/scfr_fifo.sv
// Small first-in first-out queue of registers, used between front and back
// and for the result side. Depends on nothing.
`timescale 1ns / 1ps

module scfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_pop, do_push;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_pop  = pop && !empty;
    // A beat may enter a full queue when the head leaves in the same cycle.
    assign do_push = push && (!full || do_pop);
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/scfr_front.sv
// Front end: frame hunt, running CRC and pending-frame latch; turns each tick
// into a queue entry for the back end. Depends on scfr_pkg.
`timescale 1ns / 1ps

module scfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                mode,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          sync_first,
    input  logic [7:0]          sync_second,
    output logic                item_push,
    output scfr_pkg::tick_item_t item
);

    import scfr_pkg::*;

    pos_t            pos_reg, pos_next;
    logic            pending_reg, pending_next;
    logic [2:0][7:0] cmd_reg, cmd_next;
    logic [2:0][7:0] payload_reg, payload_next;
    logic [7:0]      crc_hi_reg, crc_hi_next;
    logic [15:0]     crc_reg, crc_next;
    logic            byte_in;

    assign byte_in    = accept && !mode && !pending_reg;
    assign item_push  = accept && mode;
    assign item.fresh = pending_reg;
    assign item.cmd   = cmd_reg;

    always_comb
    begin
        pos_next     = pos_reg;
        pending_next = pending_reg;
        cmd_next     = cmd_reg;
        payload_next = payload_reg;
        crc_hi_next  = crc_hi_reg;
        crc_next     = crc_reg;
        if (item_push)
        begin
            pending_next = 1'b0;
        end
        else if (byte_in)
        begin
            unique case (pos_reg)
                POS_SYNC1:
                begin
                    if (rx_byte == sync_first)
                    begin
                        pos_next = POS_SYNC2;
                    end
                end
                POS_SYNC2:
                begin
                    pos_next = (rx_byte == sync_second) ? POS_PAY0 : POS_SYNC1;
                end
                POS_PAY0:
                begin
                    payload_next[0] = rx_byte;
                    crc_next        = crc_byte(16'h0000, rx_byte);
                    pos_next        = POS_PAY1;
                end
                POS_PAY1:
                begin
                    payload_next[1] = rx_byte;
                    crc_next        = crc_byte(crc_reg, rx_byte);
                    pos_next        = POS_PAY2;
                end
                POS_PAY2:
                begin
                    payload_next[2] = rx_byte;
                    crc_next        = crc_byte(crc_reg, rx_byte);
                    pos_next        = POS_CRC_HI;
                end
                POS_CRC_HI:
                begin
                    crc_hi_next = rx_byte;
                    pos_next    = POS_CRC_LO;
                end
                default:
                begin
                    // Final CRC byte; an impossible position is handled the same way.
                    if ({crc_hi_reg, rx_byte} == crc_reg)
                    begin
                        cmd_next     = payload_reg;
                        pending_next = 1'b1;
                    end
                    pos_next = POS_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_SYNC1;
            pending_reg <= 1'b0;
            cmd_reg     <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            cmd_reg     <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        crc_hi_reg  <= crc_hi_next;
        crc_reg     <= crc_next;
    end

endmodule

>>> rtl/scfr_back.sv
// Back end: idle tick counter, timeout check and speed registers; builds one result
// per tick taken from the queue. Depends on scfr_pkg.
`timescale 1ns / 1ps

module scfr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scfr_pkg::tick_item_t item,
    input  logic                 item_valid,
    input  logic                 res_room,
    input  logic [15:0]          timeout_ticks,
    output logic                 item_take,
    output scfr_pkg::result_t    res,
    output logic                 res_push
);

    import scfr_pkg::*;

    logic [15:0]              count_reg, count_next;
    logic [2:0][SPEED_W-1:0]  speed_reg, speed_next;
    logic [15:0]              count_inc;
    logic                     late;

    assign item_take = item_valid && res_room;
    assign res_push  = item_take;

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign late      = (count_inc > timeout_ticks);

    always_comb
    begin
        count_next = count_inc;
        speed_next = speed_reg;
        priority if (item.fresh)
        begin
            count_next = '0;
            for (int k = 0; k < 3; k++)
            begin
                speed_next[k] = speed_from_byte(item.cmd[k]);
            end
        end
        else if (late)
        begin
            speed_next = '0;
        end
        else
        begin
            speed_next = speed_reg;
        end
    end

    assign res.left_speed    = speed_next[0];
    assign res.right_speed   = speed_next[1];
    assign res.flipper_speed = speed_next[2];
    assign res.fresh_frame   = item.fresh;
    assign res.timed_out     = late && !item.fresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            speed_reg <= '0;
        end
        else if (item_take)
        begin
            count_reg <= count_next;
            speed_reg <= speed_next;
        end
    end

endmodule

>>> rtl/serial_command_frame_receiver_unit.sv
// Framed serial command receiver: bytes build CRC-checked frames, ticks turn them into speeds.
// A tick's result is written into the result queue in the cycle its queued beat is taken by the back end.
// Throughput: one byte or tick per cycle, limited only by the front-to-back and result queues.
// Bytes give no result; every tick gives exactly one.
// Reset (rst_n low, asynchronous) clears hunt, pending frame, counter, speeds and both queues,
// and loads the configuration reset values. Needs scfr_pkg, scfr_front, scfr_back, scfr_fifo.
`timescale 1ns / 1ps

module serial_command_frame_receiver_unit #(
    parameter int QUEUE_DEPTH  = 4,
    parameter int RESULT_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic signed [scfr_pkg::SPEED_W-1:0] left_speed,
    output logic signed [scfr_pkg::SPEED_W-1:0] right_speed,
    output logic signed [scfr_pkg::SPEED_W-1:0] flipper_speed,
    output logic        fresh_frame,
    output logic        timed_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import scfr_pkg::*;

    logic [15:0] timeout_reg;
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;

    logic        accept;
    logic        item_push;
    tick_item_t  item_in, item_head;
    logic        item_empty, item_full, item_take;
    result_t     res_in, res_head;
    logic        res_push, res_full, res_empty, res_room;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign full      = item_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:     timeout_reg     <= cfg_data;
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    scfr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .rx_byte     (rx_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .item_push   (item_push),
        .item        (item_in)
    );

    scfr_fifo #(
        .WIDTH ($bits(tick_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata (item_in),
        .pop   (item_take),
        .rdata (item_head),
        .empty (item_empty),
        .full  (item_full)
    );

    // The back end may fill a full result queue when the oldest beat leaves now.
    assign res_room = !res_full || (pop && !res_empty);

    scfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item_head),
        .item_valid    (!item_empty),
        .res_room      (res_room),
        .timeout_ticks (timeout_reg),
        .item_take     (item_take),
        .res           (res_in),
        .res_push      (res_push)
    );

    scfr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .pop   (pop),
        .rdata (res_head),
        .empty (res_empty),
        .full  (res_full)
    );

    assign empty         = res_empty;
    assign left_speed    = res_head.left_speed;
    assign right_speed   = res_head.right_speed;
    assign flipper_speed = res_head.flipper_speed;
    assign fresh_frame   = res_head.fresh_frame;
    assign timed_out     = res_head.timed_out;

endmodule

>>> rtl/scfr_checker.sv
// Port-level checks of the framed command receiver, bound to the top level.
// Depends on serial_command_frame_receiver_unit_defines.svh.
`timescale 1ns / 1ps
`include "serial_command_frame_receiver_unit_defines.svh"

module scfr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [11:0] left_speed,
    input logic signed [11:0] right_speed,
    input logic signed [11:0] flipper_speed,
    input logic               fresh_frame,
    input logic               timed_out
);

    logic all_zero;
    logic in_range;

    assign all_zero = (left_speed == 12'sd0) && (right_speed == 12'sd0)
                      && (flipper_speed == 12'sd0);
    assign in_range = (left_speed >= -12'sd1000) && (left_speed <= 12'sd1550)
                      && (right_speed >= -12'sd1000) && (right_speed <= 12'sd1550);

    // A new frame always overrides the timeout.
    `SCFR_ASSERT_IMPL(a_fresh_not_late, !empty, !(fresh_frame && timed_out))

    // A timed-out beat carries all speeds at zero.
    `SCFR_ASSERT_IMPL(a_late_zero, !empty && timed_out, all_zero)

    // Left and right speeds from a frame stay within the mapped byte range.
    `SCFR_ASSERT_IMPL(a_fresh_range, !empty && fresh_frame, in_range)

    // The left speed and flags of a waiting result that is not taken stay put.
    `SCFR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable({left_speed, fresh_frame, timed_out}))

endmodule

bind serial_command_frame_receiver_unit scfr_checker u_scfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .flipper_speed (flipper_speed),
    .fresh_frame   (fresh_frame),
    .timed_out     (timed_out)
);
